// File: sv/tcce_pkg.sv
// Shared types, codes and constants of the text console cursor engine.
package tcce_pkg;

   // Default tab spacing in text cells.
   localparam int TAB_STOP_DEF = 8;

   // Register reset values.
   localparam logic [7:0] COLUMNS_RST = 8'd128;
   localparam logic [7:0] ROWS_RST    = 8'd48;

   // Character codes that steer the cursor.
   localparam logic [7:0] CH_LF          = 8'h0A;
   localparam logic [7:0] CH_CR          = 8'h0D;
   localparam logic [7:0] CH_BS          = 8'h08;
   localparam logic [7:0] CH_TAB         = 8'h09;
   localparam logic [7:0] CH_FIRST_PRINT = 8'h20;
   localparam logic [7:0] CH_LAST_PRINT  = 8'h7E;

   // Glyphs that the engine substitutes.
   localparam logic [6:0] GLYPH_QMARK = 7'h3F;
   localparam logic [6:0] GLYPH_SPACE = 7'h20;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_DRAW   = 2'd0,
      KIND_SCROLL = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   // Input commands.
   typedef enum logic {
      CMD_PUT   = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_ENABLE   = 2'd0,
      REG_COLUMNS  = 2'd1,
      REG_ROWS     = 2'd2,
      REG_BG_COLOR = 2'd3
   } reg_idx_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TAB,
      ST_SCROLL
   } state_type;

   // Effective configuration seen by the sequencer (zero sizes act as one).
   typedef struct packed {
      logic       enable;
      logic [7:0] cols;
      logic [7:0] rows;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  cell_col;
      logic [7:0]  cell_row;
      logic [6:0]  glyph;
      logic [31:0] draw_color;
      logic        last;
   } res_type;

endpackage

// File: sv/tcce_core.sv
// Cursor sequencer: decodes one item and steps the column unit to emit its results.
module tcce_core
   import tcce_pkg::*;
#(
   parameter int TAB_STOP = TAB_STOP_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   input  logic        req_cmd,
   input  logic [7:0]  req_char,
   input  logic [31:0] req_fg,
   output logic        req_ready,
   input  logic        out_free,
   output logic        res_valid,
   output res_type     res
);

   localparam int PW = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;
   localparam logic [PW-1:0] PHASE_TOP = PW'(TAB_STOP - 1);

   state_type   state_ff, state_in;
   logic [7:0]  col_ff, col_in;
   logic [7:0]  row_ff, row_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic [31:0] fg_ff, fg_in;

   // Shared column step unit: one 9-bit add of plus or minus one and a compare.
   logic       step_dec;
   logic [8:0] step_sum;
   logic       step_hit;

   logic [8:0]    row_next;
   logic          row_wrap;
   logic          col_on;
   logic          row_on;
   logic [PW-1:0] phase_up;
   logic [PW-1:0] phase_down;
   logic [6:0]    glyph_put;
   logic          draw_en;
   logic          tab_end;

   assign step_dec = (state_ff == ST_IDLE) && (req_char == CH_BS);
   assign step_sum = {1'b0, col_ff} + (step_dec ? 9'h1FF : 9'd1);
   assign step_hit = step_sum >= {1'b0, cfg.cols};

   // Row increment and on-screen checks.
   assign row_next = {1'b0, row_ff} + 9'd1;
   assign row_wrap = row_next >= {1'b0, cfg.rows};
   assign col_on   = col_ff < cfg.cols;
   assign row_on   = row_ff < cfg.rows;

   // Column position within its tab stop, kept beside the column.
   assign phase_up   = (phase_ff == PHASE_TOP) ? '0 : phase_ff + PW'(1);
   assign phase_down = (phase_ff == '0) ? PHASE_TOP : phase_ff - PW'(1);

   assign glyph_put = (req_char >= CH_FIRST_PRINT && req_char <= CH_LAST_PRINT) ?
                      req_char[6:0] : GLYPH_QMARK;
   assign draw_en   = col_on && row_on;
   assign tab_end   = (phase_ff == PHASE_TOP) || step_hit;

   // State and cursor registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         phase_ff <= phase_in;
      end
   end

   // The tab color needs no reset.
   always_ff @(posedge clock) begin
      fg_ff <= fg_in;
   end

   // Next state, cursor updates and result beats.
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      phase_in  = phase_ff;
      fg_in     = fg_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      res.kind  = KIND_DRAW;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free && cfg.enable) begin
               if (req_cmd == CMD_CLEAR) begin
                  // Clear the screen and home the cursor.
                  res_valid = 1'b1;
                  res.kind  = KIND_CLEAR;
                  res.last  = 1'b1;
                  col_in    = '0;
                  row_in    = '0;
                  phase_in  = '0;
               end else if (req_char == CH_LF) begin
                  col_in   = '0;
                  phase_in = '0;
                  if (row_wrap) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_SCROLL;
                     res.last  = 1'b1;
                     row_in    = cfg.rows - 8'd1;
                  end else begin
                     row_in = row_next[7:0];
                  end
               end else if (req_char == CH_CR) begin
                  col_in   = '0;
                  phase_in = '0;
               end else if (req_char == CH_BS) begin
                  // Step back and blank the cell, if there is one to the left and it is on screen.
                  if (col_ff != '0) begin
                     col_in   = step_sum[7:0];
                     phase_in = phase_down;
                     if (!step_hit && row_on) begin
                        res_valid      = 1'b1;
                        res.cell_col   = step_sum[7:0];
                        res.cell_row   = row_ff;
                        res.glyph      = GLYPH_SPACE;
                        res.draw_color = req_fg;
                        res.last       = 1'b1;
                     end
                  end
               end else if (req_char == CH_TAB) begin
                  if (col_on) begin
                     fg_in    = req_fg;
                     state_in = ST_TAB;
                  end
               end else begin
                  // Printable or substituted character at the cursor.
                  res.cell_col   = col_ff;
                  res.cell_row   = row_ff;
                  res.glyph      = glyph_put;
                  res.draw_color = req_fg;
                  if (step_hit) begin
                     col_in   = '0;
                     phase_in = '0;
                     if (row_wrap) begin
                        row_in = cfg.rows - 8'd1;
                        if (draw_en) begin
                           res_valid = 1'b1;
                           state_in  = ST_SCROLL;
                        end else begin
                           res       = '0;
                           res.kind  = KIND_SCROLL;
                           res.last  = 1'b1;
                           res_valid = 1'b1;
                        end
                     end else begin
                        row_in    = row_next[7:0];
                        res_valid = draw_en;
                        res.last  = 1'b1;
                     end
                  end else begin
                     col_in    = step_sum[7:0];
                     phase_in  = phase_up;
                     res_valid = draw_en;
                     res.last  = 1'b1;
                  end
               end
            end
         end

         ST_TAB: begin
            // One blank cell per step while the output is free, until the tab stop or the row end.
            if (out_free) begin
               res_valid      = row_on;
               res.cell_col   = col_ff;
               res.cell_row   = row_ff;
               res.glyph      = GLYPH_SPACE;
               res.draw_color = fg_ff;
               res.last       = tab_end;
               col_in         = step_sum[7:0];
               phase_in       = phase_up;
               if (tab_end) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SCROLL: begin
            // Scroll that follows a draw in the last cell of the bottom row.
            if (out_free) begin
               res_valid = 1'b1;
               res.kind  = KIND_SCROLL;
               res.last  = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/text_console_cursor_engine.sv
// Top level of the text console cursor engine: registers, sequencer and output stage.
//
//   Channel  Direction  Beat contents
//   req_     in         tuser: command; tdata: char_code, fg_color
//   rsp_     out        tuser: kind; tlast: last; tdata: cell_col, cell_row, glyph, draw_color
//   csr_     in         write enable, register index, write data
//
// Clear, newline, carriage return, backspace and a plain character are handled in the idle state.
// A character that wraps on the bottom row gives the draw, if its cell is on screen, then the scroll.
// A tab is accepted, then emits up to TAB_STOP blank cells while the output is free.
// Reset is synchronous and homes the cursor; the sequencer is ready right after it.
// A stalled result holds in the output register and the sequencer waits behind it.
module text_console_cursor_engine
   import tcce_pkg::*;
#(
   parameter int TAB_STOP = TAB_STOP_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input beats.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] char_code, [39:8] fg_color
   input  logic        req_tuser,   // [0] command
   // Result beats.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] cell_col, [15:8] cell_row, [22:16] glyph,
                                    // [54:23] draw_color, [55] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   logic       enable_ff;
   logic [7:0] columns_ff;
   logic [7:0] rows_ff;

   cfg_type cfg;
   logic    out_free;
   logic    res_valid;
   res_type res;

   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_ff;

   // Configuration registers. The background color belongs to the renderer,
   // so a write to it is taken and has no effect here.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         columns_ff <= COLUMNS_RST;
         rows_ff    <= ROWS_RST;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_addr))
            REG_ENABLE:   enable_ff  <= csr_wdata[0];
            REG_COLUMNS:  columns_ff <= csr_wdata[7:0];
            REG_ROWS:     rows_ff    <= csr_wdata[7:0];
            REG_BG_COLOR: enable_ff  <= enable_ff;
            default:      enable_ff  <= enable_ff;
         endcase
      end
   end

   // A size of zero acts as one.
   assign cfg.enable = enable_ff;
   assign cfg.cols   = (columns_ff == '0) ? 8'd1 : columns_ff;
   assign cfg.rows   = (rows_ff == '0) ? 8'd1 : rows_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   tcce_core #(
      .TAB_STOP (TAB_STOP)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser),
      .req_char  (req_tdata[7:0]),
      .req_fg    (req_tdata[39:8]),
      .req_ready (req_tready),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register: loads a new beat whenever the sequencer emits one.
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.draw_color, rsp_ff.glyph, rsp_ff.cell_row,
                        rsp_ff.cell_col};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

endmodule
